// File: design/pktdfr_pkg.sv
// ---------------------------------------------------------------------------
// pktdfr_pkg: shared types and constants for the packet deframer
// Item structs for both channels, the emit request, and the checksum fold.
// ---------------------------------------------------------------------------
package pktdfr_pkg;

	// default payload store depth; a length at or above it aborts the frame
	localparam int unsigned MAX_DATA_DEF = 30;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned IDX_W  = 6;

	localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hAA;
	localparam logic [BYTE_W-1:0] SUM_MOD   = 8'hFF;

	// command codes on the input channel
	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_TIMEOUT = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic              is_header;
		logic [BYTE_W-1:0] out_byte;
		logic [IDX_W-1:0]  payload_index;
		logic [IDX_W-1:0]  payload_length;
		logic              last;
	} out_item_t;

	// request from the frame parser to the emit sequencer
	typedef struct packed {
		logic              start;
		logic [BYTE_W-1:0] header;
		logic [IDX_W-1:0]  length;
	} emit_req_t;

	// add a byte to the running sum modulo 255; acc may be 255 (unreduced seed)
	function automatic logic [BYTE_W-1:0] fold_sum(input logic [BYTE_W-1:0] acc,
	                                               input logic [BYTE_W-1:0] b);
		logic [BYTE_W:0] s;
		logic [BYTE_W:0] r;
		s = {1'b0, acc} + {1'b0, b};
		r = (s >= {1'b0, SUM_MOD}) ? (s - {1'b0, SUM_MOD}) : s;
		if (r == {1'b0, SUM_MOD}) begin
			r = '0;
		end
		return r[BYTE_W-1:0];
	endfunction

endpackage

// File: design/pktdfr_ram.sv
// ---------------------------------------------------------------------------
// pktdfr_ram: payload byte store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module pktdfr_ram #(
	parameter int unsigned DEPTH = pktdfr_pkg::MAX_DATA_DEF
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH)-1:0]         waddr,
	input  logic [pktdfr_pkg::BYTE_W-1:0]    wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH)-1:0]         raddr,
	output logic [pktdfr_pkg::BYTE_W-1:0]    rdata
);

	logic [pktdfr_pkg::BYTE_W-1:0] mem [DEPTH];
	logic [pktdfr_pkg::BYTE_W-1:0] rdata_q;

	// write incoming payload byte
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// register read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/pktdfr_emit.sv
// ---------------------------------------------------------------------------
// pktdfr_emit: packet emit sequencer
// Presents the header item, then walks the payload store one item per cycle
// while the output is not stalled, issuing each read as the previous item is taken.
// ---------------------------------------------------------------------------
module pktdfr_emit #(
	parameter int unsigned MAX_DATA = pktdfr_pkg::MAX_DATA_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pktdfr_pkg::emit_req_t              req,
	output logic                               busy,
	output logic                               rd_en,
	output logic [$clog2(MAX_DATA)-1:0]        rd_addr,
	input  logic [pktdfr_pkg::BYTE_W-1:0]      rd_data,
	output logic                               pkt_valid,
	input  logic                               pkt_stall,
	output pktdfr_pkg::out_item_t              pkt_data
);

	localparam int unsigned AW = $clog2(MAX_DATA);

	localparam logic [1:0] EM_IDLE = 2'd0;
	localparam logic [1:0] EM_HDR  = 2'd1;
	localparam logic [1:0] EM_DATA = 2'd2;

	logic [1:0]                          state_q;
	logic [pktdfr_pkg::BYTE_W-1:0]       hdr_q;
	logic [pktdfr_pkg::IDX_W-1:0]        len_q;
	logic [pktdfr_pkg::IDX_W-1:0]        idx_q;
	logic                                take;
	logic                                is_last;
	logic [pktdfr_pkg::IDX_W-1:0]        next_idx;

	assign take     = pkt_valid && !pkt_stall;
	assign is_last  = (state_q == EM_HDR) ? (len_q == '0)
	                                      : (idx_q == len_q - 6'd1);
	assign next_idx = (state_q == EM_HDR) ? '0 : (idx_q + 6'd1);

	// fetch the next payload byte when the current item is taken
	assign rd_en   = take && !is_last;
	assign rd_addr = next_idx[AW-1:0];

	// sequence header then payload items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				EM_IDLE: begin
					if (req.start) begin
						state_q <= EM_HDR;
						idx_q   <= '0;
					end
				end
				EM_HDR, EM_DATA: begin
					if (take) begin
						if (is_last) begin
							state_q <= EM_IDLE;
						end else begin
							state_q <= EM_DATA;
							idx_q   <= next_idx;
						end
					end
				end
				default: begin
					state_q <= EM_IDLE;
				end
			endcase
		end
	end

	// capture packet header and length at start
	always_ff @(posedge clk) begin
		if (req.start && state_q == EM_IDLE) begin
			hdr_q <= req.header;
			len_q <= req.length;
		end
	end

	assign busy      = (state_q != EM_IDLE);
	assign pkt_valid = busy;

	always_comb begin
		pkt_data.is_header      = (state_q == EM_HDR);
		pkt_data.out_byte       = (state_q == EM_HDR) ? hdr_q : rd_data;
		pkt_data.payload_index  = (state_q == EM_HDR) ? '0 : idx_q;
		pkt_data.payload_length = len_q;
		pkt_data.last           = is_last;
	end

	// a start request only arrives while the sequencer is idle
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == EM_IDLE)
		else $error("emit start while busy");

	// payload index stays inside the packet length
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == EM_DATA |-> idx_q < len_q)
		else $error("payload index beyond length");

	// taking the last item returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(take && is_last) |=> state_q == EM_IDLE)
		else $error("sequencer busy after last item");

	// every fetch addresses a slot of the store
	a_rd_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> {26'd0, next_idx} < MAX_DATA)
		else $error("store read out of range");

endmodule

// File: design/packet_deframer_mod255_checksum.sv
// ---------------------------------------------------------------------------
// packet_deframer_mod255_checksum: sync / length / checksum packet deframer
// Parses 0xAA 0xAA header length payload checksum frames, stores the payload
// and emits header plus payload items on a checksum match.
// ---------------------------------------------------------------------------
// Input: one byte item per cycle while idle; the input stalls while a packet
//   is being emitted, including any output stall.
// Output: the header item is presented in the cycle after the checksum byte;
//   payload items follow one per cycle unless stalled, paced by registered reads.
// Reset: parser returns to sync hunting and the emitter to idle at once;
//   the payload store is not cleared and needs no clearing pass.
module packet_deframer_mod255_checksum #(
	parameter int unsigned MAX_DATA = pktdfr_pkg::MAX_DATA_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     byte_valid,
	output logic                     byte_stall,
	input  pktdfr_pkg::in_item_t     byte_data,
	output logic                     pkt_valid,
	input  logic                     pkt_stall,
	output pktdfr_pkg::out_item_t    pkt_data
);

	localparam int unsigned AW = $clog2(MAX_DATA);

	localparam logic [2:0] PH_SYNC1   = 3'd0;
	localparam logic [2:0] PH_SYNC2   = 3'd1;
	localparam logic [2:0] PH_HEADER  = 3'd2;
	localparam logic [2:0] PH_LENGTH  = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_CHECK   = 3'd5;

	logic [2:0]                      phase_q;
	logic [pktdfr_pkg::BYTE_W-1:0]   header_q;
	logic [pktdfr_pkg::IDX_W-1:0]    length_q;
	logic [pktdfr_pkg::IDX_W-1:0]    fill_q;
	logic [pktdfr_pkg::BYTE_W-1:0]   sum_q;

	logic                            accept;
	logic                            is_byte;
	logic [pktdfr_pkg::BYTE_W-1:0]   c;
	logic [pktdfr_pkg::BYTE_W-1:0]   sum_next;
	logic [pktdfr_pkg::IDX_W-1:0]    fill_next;
	logic                            busy;
	logic                            wr_en;
	logic                            rd_en;
	logic [AW-1:0]                   rd_addr;
	logic [pktdfr_pkg::BYTE_W-1:0]   rd_data;
	pktdfr_pkg::emit_req_t           req;

	assign byte_stall = busy;
	assign accept     = byte_valid && !byte_stall;
	assign is_byte    = (byte_data.cmd == pktdfr_pkg::CMD_BYTE);
	assign c          = byte_data.rx_byte;
	assign sum_next   = pktdfr_pkg::fold_sum(sum_q, c);
	assign fill_next  = fill_q + 6'd1;

	// parse frame fields
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SYNC1;
			header_q <= '0;
			length_q <= '0;
			fill_q   <= '0;
			sum_q    <= '0;
		end else if (accept) begin
			if (!is_byte) begin
				phase_q <= PH_SYNC1;
			end else begin
				unique case (phase_q)
					PH_SYNC2: begin
						phase_q <= (c == pktdfr_pkg::SYNC_BYTE) ? PH_HEADER : PH_SYNC1;
					end
					PH_HEADER: begin
						header_q <= c;
						sum_q    <= c;
						phase_q  <= PH_LENGTH;
					end
					PH_LENGTH: begin
						if (c < 8'(MAX_DATA)) begin
							length_q <= c[pktdfr_pkg::IDX_W-1:0];
							sum_q    <= sum_next;
							fill_q   <= '0;
							phase_q  <= (c != '0) ? PH_PAYLOAD : PH_CHECK;
						end else begin
							phase_q <= PH_SYNC1;
						end
					end
					PH_PAYLOAD: begin
						sum_q  <= sum_next;
						fill_q <= fill_next;
						if (fill_next >= length_q) begin
							phase_q <= PH_CHECK;
						end
					end
					PH_CHECK: begin
						phase_q <= PH_SYNC1;
					end
					default: begin
						phase_q <= (c == pktdfr_pkg::SYNC_BYTE) ? PH_SYNC2 : PH_SYNC1;
					end
				endcase
			end
		end
	end

	// store payload bytes; request emit on checksum match
	assign wr_en = accept && is_byte && (phase_q == PH_PAYLOAD);

	always_comb begin
		req.start  = accept && is_byte && (phase_q == PH_CHECK) && (sum_q == c);
		req.header = header_q;
		req.length = length_q;
	end

	pktdfr_ram #(
		.DEPTH (MAX_DATA)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (fill_q[AW-1:0]),
		.wdata (c),
		.re    (rd_en),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	pktdfr_emit #(
		.MAX_DATA (MAX_DATA)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.busy      (busy),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt_data  (pkt_data)
	);

	// payload writes stay inside the announced length
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (fill_q < length_q) && ({26'd0, fill_q} < MAX_DATA))
		else $error("payload write beyond length");

	// no store write while a packet is being read out
	a_no_wr_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !wr_en)
		else $error("store write during emit");

endmodule

// File: tb/sv/packet_deframer_mod255_checksum_test.sv
// ---------------------------------------------------------------------------
// packet_deframer_mod255_checksum_test: self-checking bench for the deframer
// Feeds framed and unframed byte streams with timeouts and idle gaps, tracks
// the expected packet items with a local frame parser, and checks every
// emitted item field by field in arrival order.
// ---------------------------------------------------------------------------
module packet_deframer_mod255_checksum_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STORE_DEPTH = pktdfr_pkg::MAX_DATA_DEF;
	localparam int unsigned ITEMS_PER_PHASE = 30;

	typedef enum logic [2:0] {
		HUNT_SYNC1, HUNT_SYNC2, GET_HEADER, GET_LENGTH, GET_PAYLOAD, GET_CHECK
	} frame_phase_t;

	logic clk;
	logic arst_n;
	logic byte_valid = 1'b0;
	logic byte_stall;
	pktdfr_pkg::in_item_t byte_data = '0;
	logic pkt_valid;
	logic pkt_stall = 1'b0;
	pktdfr_pkg::out_item_t pkt_data;

	// pending bytes and expected packet items
	pktdfr_pkg::in_item_t rx_item_q[$];
	pktdfr_pkg::out_item_t pkt_expect_q[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned err_count = 0;
	int unsigned frame_items = 0;

	// local frame parser state
	frame_phase_t fr_phase = HUNT_SYNC1;
	logic [7:0] fr_header = '0;
	logic [5:0] fr_length = '0;
	logic [5:0] fr_fill = '0;
	logic [7:0] fr_sum = '0;
	logic [7:0] fr_store[STORE_DEPTH];

	packet_deframer_mod255_checksum i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.byte_data(byte_data),
		.pkt_valid(pkt_valid),
		.pkt_stall(pkt_stall),
		.pkt_data(pkt_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop if the run hangs
	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] add_mod255(input logic [7:0] acc, input logic [7:0] b);
		int unsigned s;
		s = int'(acc) + int'(b);
		return 8'(s % 255);
	endfunction

	// advance the frame parser by one accepted item and queue what it emits
	task automatic deframe_item(input pktdfr_pkg::in_item_t it);
		pktdfr_pkg::out_item_t e;
		if (it.cmd == pktdfr_pkg::CMD_TIMEOUT) begin
			fr_phase = HUNT_SYNC1;
			return;
		end
		case (fr_phase)
			HUNT_SYNC2: begin
				fr_phase = (it.rx_byte == pktdfr_pkg::SYNC_BYTE) ? GET_HEADER : HUNT_SYNC1;
			end
			GET_HEADER: begin
				fr_header = it.rx_byte;
				fr_sum = it.rx_byte;
				fr_phase = GET_LENGTH;
			end
			GET_LENGTH: begin
				if (it.rx_byte < STORE_DEPTH) begin
					fr_length = it.rx_byte[5:0];
					fr_sum = add_mod255(fr_sum, it.rx_byte);
					fr_fill = '0;
					fr_phase = (it.rx_byte != 8'd0) ? GET_PAYLOAD : GET_CHECK;
				end else begin
					fr_phase = HUNT_SYNC1;
				end
			end
			GET_PAYLOAD: begin
				if (fr_fill < STORE_DEPTH) begin
					fr_store[fr_fill] = it.rx_byte;
				end
				fr_sum = add_mod255(fr_sum, it.rx_byte);
				fr_fill = fr_fill + 6'd1;
				if (fr_fill >= fr_length) begin
					fr_phase = GET_CHECK;
				end
			end
			GET_CHECK: begin
				if (fr_sum == it.rx_byte) begin
					e = '{is_header: 1'b1, out_byte: fr_header, payload_index: '0,
						payload_length: fr_length, last: (fr_length == 6'd0)};
					pkt_expect_q.push_back(e);
					for (int i = 0; i < int'(fr_length) && i < STORE_DEPTH; i++) begin
						e = '{is_header: 1'b0, out_byte: fr_store[i], payload_index: 6'(i),
							payload_length: fr_length, last: (i + 1 == int'(fr_length))};
						pkt_expect_q.push_back(e);
					end
				end
				fr_phase = HUNT_SYNC1;
			end
			default: begin
				fr_phase = (it.rx_byte == pktdfr_pkg::SYNC_BYTE) ? HUNT_SYNC2 : HUNT_SYNC1;
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t: mismatch: %s", $realtime, msg);
		err_count++;
	endtask

	task automatic check_field(input string fname, input int got, input int want);
		if (got != want) begin
			report_mismatch($sformatf("%s got %0d expected %0d", fname, got, want));
		end
	endtask

	// stimulus helpers
	task automatic push_byte(input logic [7:0] b);
		rx_item_q.push_back('{cmd: pktdfr_pkg::CMD_BYTE, rx_byte: b});
	endtask

	task automatic push_timeout();
		rx_item_q.push_back('{cmd: pktdfr_pkg::CMD_TIMEOUT, rx_byte: 8'($urandom_range(255))});
	endtask

	// build one frame; a bad length stops after the length byte, cut_at >= 0
	// replaces that frame position with a timeout and ends the frame there
	task automatic push_frame(input logic [7:0] hdr, input logic [7:0] len,
		input bit bad_sum, input int cut_at);
		logic [7:0] bytes[$];
		logic [7:0] sum;
		logic [7:0] p;
		bytes = '{pktdfr_pkg::SYNC_BYTE, pktdfr_pkg::SYNC_BYTE, hdr, len};
		sum = add_mod255(hdr, len);
		if (len < STORE_DEPTH) begin
			for (int i = 0; i < int'(len); i++) begin
				p = 8'($urandom_range(255));
				bytes.push_back(p);
				sum = add_mod255(sum, p);
			end
			bytes.push_back(bad_sum ? (sum ^ 8'($urandom_range(1, 255))) : sum);
		end
		foreach (bytes[i]) begin
			if (i == cut_at) begin
				push_timeout();
				frame_items++;
				return;
			end
			push_byte(bytes[i]);
			frame_items++;
		end
	endtask

	task automatic load_random(input int unsigned n);
		int unsigned r;
		int unsigned len;
		int cut;
		frame_items = 0;
		while (frame_items < n) begin
			r = $urandom_range(99);
			if (r < 70) begin
				r = $urandom_range(99);
				if (r < 80) len = $urandom_range(6);
				else if (r < 92) len = $urandom_range(STORE_DEPTH - 1, 7);
				else len = STORE_DEPTH - 1;
				cut = ($urandom_range(99) < 8) ? int'($urandom_range(len + 4)) : -1;
				push_frame(8'($urandom_range(255)), 8'(len), $urandom_range(99) < 15, cut);
			end else if (r < 80) begin
				push_frame(8'($urandom_range(255)), 8'($urandom_range(255, STORE_DEPTH)), 1'b0, -1);
			end else if (r < 90) begin
				push_byte(($urandom_range(1)) ? pktdfr_pkg::SYNC_BYTE : 8'($urandom_range(255)));
			end else begin
				push_timeout();
			end
		end
	endtask

	// hold until every item is sent and every expected result has come
	task automatic drain();
		while (rx_item_q.size() != 0 || byte_valid || pkt_expect_q.size() != 0) begin
			@(negedge clk);
		end
	endtask

	// driver: present the next item once the current one is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			byte_data <= '0;
		end else if (!byte_valid || !byte_stall) begin
			if (rx_item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				byte_valid <= 1'b1;
				byte_data <= rx_item_q.pop_front();
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_stall <= 1'b0;
		end else begin
			pkt_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// monitor: check emitted items, then track accepted input items
	always @(posedge clk) begin
		pktdfr_pkg::out_item_t want;
		if (arst_n) begin
			if (pkt_valid && !pkt_stall) begin
				if (pkt_expect_q.size() == 0) begin
					report_mismatch($sformatf("unexpected item %p", pkt_data));
				end else begin
					want = pkt_expect_q.pop_front();
					check_field("is_header", pkt_data.is_header, want.is_header);
					check_field("out_byte", pkt_data.out_byte, want.out_byte);
					check_field("payload_index", pkt_data.payload_index, want.payload_index);
					check_field("payload_length", pkt_data.payload_length, want.payload_length);
					check_field("last", pkt_data.last, want.last);
				end
			end
			if (byte_valid && !byte_stall) begin
				deframe_item(byte_data);
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: header 0xFF seed with zero length, then a timeout
		push_frame(8'hFF, 8'd0, 1'b0, -1);
		push_timeout();
		// length at the abort limit
		push_frame(8'h00, 8'(STORE_DEPTH), 1'b0, -1);
		// second sync mismatch, then a stray sync before the next frame
		push_byte(pktdfr_pkg::SYNC_BYTE);
		push_byte(8'h55);
		push_byte(pktdfr_pkg::SYNC_BYTE);
		// bad checksum on a one-byte payload
		push_frame(8'h01, 8'd1, 1'b1, -1);
		// timeout in the middle of the payload
		push_frame(8'h7E, 8'd2, 1'b0, 5);
		// good two-byte frame after the timeout
		push_frame(8'h80, 8'd2, 1'b0, -1);
		drain();

		// random phases: no idling, sender idle, receiver stall, both light
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 69 : (ph == 3) ? 10 : 0;
			recv_stall_pct = (ph == 2) ? 69 : (ph == 3) ? 10 : 0;
			load_random(ITEMS_PER_PHASE);
			drain();
		end

		repeat (40) @(posedge clk);
		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: files.f
design/pktdfr_pkg.sv
design/pktdfr_ram.sv
design/pktdfr_emit.sv
design/packet_deframer_mod255_checksum.sv
tb/sv/packet_deframer_mod255_checksum_test.sv
